/* sv/kft_pkg.sv */
// ----------------------------------------------------------------------------
// kft_pkg
// Shared types and constants for the keyed flag table.
// ----------------------------------------------------------------------------
package kft_pkg;

  localparam int KFT_TABLE_DEPTH = 64;
  localparam int KFT_COUNT_W     = 7;

  typedef enum logic [1:0] {
    OP_SET       = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_CLEAR_ALL = 2'd2,
    OP_QUERY     = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key_id;
    logic [31:0] flag_mask;
  } req_item_t;

  typedef struct packed {
    logic                   match_all;
    logic                   add_dropped;
    logic [KFT_COUNT_W-1:0] live_count;
  } rsp_item_t;

  typedef struct packed {
    op_t         op;
    logic        search;
    logic [31:0] key;
    logic [31:0] flags;
  } cmd_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] mask;
  } entry_t;

endpackage

/* sv/keyed_flag_table.sv */
// ----------------------------------------------------------------------------
// keyed_flag_table
// Key/flag-mask table with linear search, set, clear with swap-delete,
// clear-all and query.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  kft_pkg::req_item_t
//   rsp      out        rsp_valid / rsp_ready  kft_pkg::rsp_item_t
//
// A request taken by the queue is registered there before the engine sees
// it. One request at a time in the engine: clear-all completes in the idle
// state, a search scans the entries one RAM read per cycle, a miss then
// passes through the miss state, and a delete that moves the last entry
// passes through the fetch-last and move states. A two-entry queue takes
// requests while the engine works or a response stalls. Synchronous reset empties the table.
// ----------------------------------------------------------------------------
module keyed_flag_table #(
  parameter int TABLE_DEPTH = kft_pkg::KFT_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  kft_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output kft_pkg::rsp_item_t rsp
);
  import kft_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  kft_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  kft_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule

/* sv/kft_ram.sv */
// ----------------------------------------------------------------------------
// kft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kft_ram #(
  parameter int Width = 64,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [Width-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [Width-1:0] rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/kft_front.sv */
// ----------------------------------------------------------------------------
// kft_front
// Accepts requests, decodes them into commands and holds them in a
// two-entry queue ahead of the table engine.
// ----------------------------------------------------------------------------
module kft_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  kft_pkg::req_item_t req,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output kft_pkg::cmd_t      cmd
);
  import kft_pkg::*;

  cmd_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  cmd_t       decoded;
  logic       push;
  logic       pop;

  always_comb begin
    decoded.op     = op_t'(req.req_type);
    decoded.search = (op_t'(req.req_type) != OP_CLEAR_ALL);
    decoded.key    = req.key_id;
    decoded.flags  = req.flag_mask;
  end

  assign req_ready = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rptr];
  assign push      = req_valid && req_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= decoded;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* sv/kft_back.sv */
// ----------------------------------------------------------------------------
// kft_back
// Table engine: linear key search over the entry RAM, flag update,
// append, swap-delete, clear-all and query, with a registered response.
// ----------------------------------------------------------------------------
module kft_back #(
  parameter int TABLE_DEPTH = kft_pkg::KFT_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  kft_pkg::cmd_t      cmd,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output kft_pkg::rsp_item_t rsp
);
  import kft_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MISS,
    ST_FETCH_LAST,
    ST_MOVE
  } state_t;

  state_t      state;
  logic [AW-1:0] idx;
  logic [CW-1:0] count;
  op_t         op;
  logic [31:0] key;
  logic [31:0] flags;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;
  entry_t        rd_entry;

  logic [CW-1:0] idx_ext;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] last_idx;
  logic          hit;
  logic [31:0]   cleared;
  logic          room;
  logic          out_free;
  logic          rsp_load;
  rsp_item_t     rsp_next;

  kft_ram #(
    .Width($bits(entry_t)),
    .Depth(TABLE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign idx_ext   = CW'(idx);
  assign idx_inc   = idx_ext + CW'(1);
  assign last_idx  = count - CW'(1);
  assign hit       = (rd_entry.key == key);
  assign cleared   = rd_entry.mask & ~flags;
  assign room      = (count < CW'(TABLE_DEPTH));
  assign out_free  = !rsp_valid || rsp_ready;
  assign cmd_ready = (state == ST_IDLE) && out_free;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '{key: key, mask: flags};
    ram_raddr = AW'(idx_inc);
    unique case (state)
      ST_IDLE: begin
        ram_raddr = '0;
      end
      ST_SEARCH: begin
        if (hit && op == OP_SET) begin
          ram_we    = 1'b1;
          ram_wdata = '{key: rd_entry.key, mask: rd_entry.mask | flags};
        end else if (hit && op == OP_CLEAR && cleared != 32'd0) begin
          ram_we    = 1'b1;
          ram_wdata = '{key: rd_entry.key, mask: cleared};
        end
      end
      ST_MISS: begin
        ram_waddr = AW'(count);
        ram_we    = (op == OP_SET) && room;
      end
      ST_FETCH_LAST: begin
        ram_raddr = AW'(last_idx);
      end
      ST_MOVE: begin
        ram_we    = 1'b1;
        ram_wdata = rd_entry;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    rsp_load = 1'b0;
    rsp_next = '{match_all: 1'b0, add_dropped: 1'b0, live_count: KFT_COUNT_W'(count)};
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free && !cmd.search) begin
          rsp_load            = 1'b1;
          rsp_next.live_count = '0;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          unique case (op)
            OP_QUERY: begin
              rsp_load           = 1'b1;
              rsp_next.match_all = ((rd_entry.mask & flags) == flags);
            end
            OP_CLEAR: begin
              if (cleared != 32'd0) begin
                rsp_load = 1'b1;
              end else if (idx_ext == last_idx) begin
                rsp_load            = 1'b1;
                rsp_next.live_count = KFT_COUNT_W'(last_idx);
              end
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end
      ST_MISS: begin
        rsp_load = 1'b1;
        if (op == OP_SET) begin
          if (room) begin
            rsp_next.live_count = KFT_COUNT_W'(count + CW'(1));
          end else begin
            rsp_next.add_dropped = 1'b1;
          end
        end
      end
      ST_MOVE: begin
        rsp_load            = 1'b1;
        rsp_next.live_count = KFT_COUNT_W'(last_idx);
      end
      default: begin
        rsp_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid && out_free) begin
            op    <= cmd.op;
            key   <= cmd.key;
            flags <= cmd.flags;
            idx   <= '0;
            if (!cmd.search) begin
              count <= '0;
            end else if (count == '0) begin
              state <= ST_MISS;
            end else begin
              state <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (hit) begin
            if (op == OP_CLEAR && cleared == 32'd0) begin
              if (idx_ext == last_idx) begin
                state <= ST_IDLE;
                count <= last_idx;
              end else begin
                state <= ST_FETCH_LAST;
              end
            end else begin
              state <= ST_IDLE;
            end
          end else if (idx_inc == count) begin
            state <= ST_MISS;
          end else begin
            idx <= AW'(idx_inc);
          end
        end
        ST_MISS: begin
          state <= ST_IDLE;
          if (op == OP_SET && room) begin
            count <= count + CW'(1);
          end
        end
        ST_FETCH_LAST: begin
          state <= ST_MOVE;
        end
        ST_MOVE: begin
          state <= ST_IDLE;
          count <= last_idx;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/kft_checker.sv */
// ----------------------------------------------------------------------------
// kft_checker
// Port-level checks for the keyed flag table, bound to the top level.
// ----------------------------------------------------------------------------
module kft_checker #(
  parameter int TABLE_DEPTH = kft_pkg::KFT_TABLE_DEPTH
) (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input kft_pkg::req_item_t req,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input kft_pkg::rsp_item_t rsp
);
  import kft_pkg::*;

  localparam logic SmallTable = (TABLE_DEPTH < 128);
  localparam logic [KFT_COUNT_W-1:0] DepthCount = KFT_COUNT_W'(TABLE_DEPTH);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.match_all && rsp.add_dropped))
    else $error("match_all and add_dropped both set");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !SmallTable || (rsp.live_count <= DepthCount))
    else $error("live_count beyond table depth");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.add_dropped |-> !SmallTable || (rsp.live_count == DepthCount))
    else $error("add dropped while table not full");

  a_reset_ready: assert property (@(posedge clk)
    $fell(rst) |-> !rsp_valid && req_ready)
    else $error("not empty after reset");

endmodule

bind keyed_flag_table kft_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_kft_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);

/* bench/tb_keyed_flag_table.sv */
// ----------------------------------------------------------------------------
// tb_keyed_flag_table
// Drives set, clear, clear-all and query requests into the keyed flag table
// and checks every response against a table model kept in the bench. Random
// traffic uses a small key pool so hits, merges, swap-deletes and full-table
// drops all occur. Both channels idle in short random bursts, and the
// response side holds off once for a long stretch to back up the request side.
// ----------------------------------------------------------------------------
module tb_keyed_flag_table;
  timeunit 1ns;
  timeprecision 1ps;

  import kft_pkg::*;

  localparam int N_ITEMS     = 650;
  localparam int POOL_SIZE   = 96;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_LEN    = 150;
  localparam int CALM_TAIL   = 60;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  keyed_flag_table DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // table model
  logic [31:0] tbl_key  [KFT_TABLE_DEPTH];
  logic [31:0] tbl_mask [KFT_TABLE_DEPTH];
  int          tbl_used = 0;

  req_item_t   request_q [$];
  rsp_item_t   outcome_q [$];
  logic [31:0] key_pool  [POOL_SIZE];

  int unsigned cycles = 0;
  int          offered = 0;
  int          accepted = 0;
  int          errors = 0;
  int          idle_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          op_seen [4] = '{default: 0};
  int          drops_seen = 0;
  int          hits_seen = 0;
  int          peak_count = 0;

  function automatic rsp_item_t table_apply(req_item_t r);
    rsp_item_t o;
    int        slot;
    o    = '0;
    slot = -1;
    for (int i = 0; i < tbl_used; i++) begin
      if (slot < 0 && tbl_key[i] == r.key_id) slot = i;
    end
    case (op_t'(r.req_type))
      OP_SET: begin
        if (slot >= 0) begin
          tbl_mask[slot] |= r.flag_mask;
        end else if (tbl_used < KFT_TABLE_DEPTH) begin
          tbl_key[tbl_used]  = r.key_id;
          tbl_mask[tbl_used] = r.flag_mask;
          tbl_used++;
        end else begin
          o.add_dropped = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (slot >= 0) begin
          tbl_mask[slot] &= ~r.flag_mask;
          if (tbl_mask[slot] == '0) begin
            tbl_key[slot]  = tbl_key[tbl_used-1];
            tbl_mask[slot] = tbl_mask[tbl_used-1];
            tbl_used--;
          end
        end
      end
      OP_CLEAR_ALL: begin
        tbl_used = 0;
      end
      OP_QUERY: begin
        o.match_all = (slot >= 0) && ((tbl_mask[slot] & r.flag_mask) == r.flag_mask);
      end
    endcase
    o.live_count = KFT_COUNT_W'(tbl_used);
    return o;
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return '1;
      2:       return '0;
      3:       return 32'h1 << $urandom_range(0, 31);
      4:       return $urandom & $urandom & $urandom;
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  task automatic push_req(op_t op, logic [31:0] key, logic [31:0] mask);
    req_item_t item;
    item.req_type  = op;
    item.key_id    = key;
    item.flag_mask = mask;
    request_q.push_back(item);
  endtask

  // driver
  always @(negedge clk) begin : drive
    req_item_t nxt;
    logic      nxt_valid;
    nxt       = req;
    nxt_valid = req_valid;
    if (!rst) begin
      if (req_valid && accepted == offered) nxt_valid = 1'b0;
      if (!nxt_valid && request_q.size() > 0) begin
        if (idle_left > 0) begin
          idle_left--;
        end else begin
          nxt       = request_q.pop_front();
          nxt_valid = 1'b1;
          offered++;
          if (request_q.size() >= CALM_TAIL && $urandom_range(0, 3) == 0)
            idle_left = $urandom_range(1, 3);
        end
      end
    end
    req_valid <= nxt_valid;
    req       <= nxt;
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (!hold_done && accepted >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN - 1;
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if (request_q.size() >= CALM_TAIL && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    rsp_item_t want;
    cycles++;
    if (!rst) begin
      if (req_valid && req_ready) begin
        accepted++;
        op_seen[req.req_type]++;
        outcome_q.push_back(table_apply(req));
      end
      if (rsp_valid && rsp_ready) begin
        if (rsp.add_dropped) drops_seen++;
        if (rsp.match_all) hits_seen++;
        if (int'(rsp.live_count) > peak_count) peak_count = rsp.live_count;
        if (outcome_q.size() == 0) begin
          $error("response with nothing outstanding: %p", rsp);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          if (rsp.match_all !== want.match_all) begin
            $error("match_all: expected %0d, got %0d", want.match_all, rsp.match_all);
            errors++;
          end
          if (rsp.add_dropped !== want.add_dropped) begin
            $error("add_dropped: expected %0d, got %0d", want.add_dropped, rsp.add_dropped);
            errors++;
          end
          if (rsp.live_count !== want.live_count) begin
            $error("live_count: expected %0d, got %0d", want.live_count, rsp.live_count);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int          sel;
    int          base;
    int          fills;
    logic [31:0] k;
    fills = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    push_req(OP_QUERY,     32'h0,         32'h0);
    push_req(OP_CLEAR,     32'h0,         '1);
    push_req(OP_SET,       32'h0,         32'h0);
    push_req(OP_QUERY,     32'h0,         32'h0);
    push_req(OP_QUERY,     32'h0,         32'h1);
    push_req(OP_CLEAR,     32'h0,         32'h0);
    push_req(OP_SET,       '1,            '1);
    push_req(OP_SET,       32'h1,         32'h8000_0000);
    push_req(OP_SET,       '1,            32'h0);
    push_req(OP_QUERY,     '1,            '1);
    push_req(OP_CLEAR,     '1,            32'h0000_FFFF);
    push_req(OP_QUERY,     '1,            32'hFFFF_0000);
    push_req(OP_QUERY,     '1,            '1);
    push_req(OP_CLEAR,     32'h1234_5678, '1);
    push_req(OP_SET,       32'hA5A5_A5A5, 32'h5A5A_5A5A);
    push_req(OP_CLEAR,     '1,            '1);
    push_req(OP_QUERY,     32'hA5A5_A5A5, 32'h5A5A_5A5A);
    push_req(OP_QUERY,     32'h1,         32'h8000_0000);
    push_req(OP_CLEAR,     32'hA5A5_A5A5, '1);
    push_req(OP_CLEAR,     32'h1,         '1);
    push_req(OP_SET,       32'h5A5A_5A5A, '1);
    push_req(OP_CLEAR_ALL, '1,            '1);
    push_req(OP_QUERY,     32'h5A5A_5A5A, 32'h0);

    while (request_q.size() < N_ITEMS) begin
      if (fills < 3 && (fills == 0 || $urandom_range(0, 99) < 2)) begin
        // fill past capacity so the tail sets drop
        push_req(OP_CLEAR_ALL, $urandom, $urandom);
        base = $urandom_range(0, POOL_SIZE - 71);
        for (int i = 0; i < 70; i++) push_req(OP_SET, key_pool[base+i], pick_mask());
        fills++;
      end else begin
        k   = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE-1)];
        sel = $urandom_range(0, 99);
        if (sel < 40)      push_req(OP_SET, k, pick_mask());
        else if (sel < 65) push_req(OP_CLEAR, k, pick_mask());
        else if (sel < 97) push_req(OP_QUERY, k, pick_mask());
        else               push_req(OP_CLEAR_ALL, k, $urandom);
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while ((request_q.size() != 0 || req_valid || outcome_q.size() != 0)
           && cycles < CYCLE_LIMIT)
      @(posedge clk);

    if (cycles >= CYCLE_LIMIT) begin
      $display("[keyed_flag_table] ERROR");
    end else begin
      repeat (KFT_TABLE_DEPTH + 10) @(posedge clk);
      if (outcome_q.size() != 0) begin
        $error("%0d responses never arrived", outcome_q.size());
        errors++;
      end
      $display("covered %0d requests: %0d set, %0d clear, %0d clear-all, %0d query",
               accepted, op_seen[OP_SET], op_seen[OP_CLEAR], op_seen[OP_CLEAR_ALL],
               op_seen[OP_QUERY]);
      $display("saw %0d dropped adds, %0d query hits, peak occupancy %0d, %0d mismatches",
               drops_seen, hits_seen, peak_count, errors);
      if (errors == 0) begin
        $display("[keyed_flag_table] OK");
      end else begin
        $display("[keyed_flag_table] ERROR");
      end
    end
    $finish;
  end

endmodule
